@@ hw/rtl/hsc_pkg.sv @@
// ---------------------------------------------------------------------------
// hsc_pkg : shared types and helpers for the Hermite coefficient builder
// Fixed-point widths, the job record between front and back, saturation.
// ---------------------------------------------------------------------------
package hsc_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int COEF_W          = 48;
    localparam int VAL_MAX_W       = 48;   // widest knot field carried in a job
    localparam int ACC_W           = 56;   // coefficient working width
    localparam int TIME_W          = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic signed [COEF_W-1:0] CMAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] CMIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SAT       = 2'd1,
        ST_ZERO_GAP  = 2'd2,
        ST_FEW_KNOTS = 2'd3
    } t_status;

    // one classified knot, front to back
    typedef struct packed {
        logic                        err;    // curve closed with too few knots
        logic                        first;  // third knot: start tangent from end formula
        logic                        fin;
        logic signed [VAL_MAX_W:0]   dp;
        logic signed [VAL_MAX_W:0]   dt;
        logic signed [VAL_MAX_W-1:0] older_time;
        logic signed [VAL_MAX_W-1:0] older_value;
        logic signed [VAL_MAX_W-1:0] newer_time;
        logic signed [VAL_MAX_W-1:0] newer_value;
        logic signed [VAL_MAX_W-1:0] cur_value;
    } t_job;

    typedef struct packed {
        logic                     ovf;
        logic signed [COEF_W-1:0] val;
    } t_sat;

    typedef struct packed {
        logic signed [COEF_W-1:0] a0;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
        logic signed [COEF_W-1:0] a3;
        t_status                  status;
    } t_coefs;

    function automatic t_status max_status(input t_status a, input t_status b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_sat sat_coef(input logic signed [ACC_W-1:0] v);
        t_sat r;
        r.ovf = 1'b0;
        r.val = COEF_W'(v);
        if (v > ACC_W'(CMAX)) begin
            r.ovf = 1'b1;
            r.val = CMAX;
        end else if (v < ACC_W'(CMIN)) begin
            r.ovf = 1'b1;
            r.val = CMIN;
        end
        return r;
    endfunction

    // a0 = p0, a1 = q0, a2 = 3(p1-p0) - 2(q0+q1), a3 = 2(p0-p1) + q0 + q1
    function automatic t_coefs make_seg(
        input logic signed [VAL_MAX_W-1:0] p0,
        input logic signed [VAL_MAX_W-1:0] p1,
        input logic signed [COEF_W-1:0]    q0,
        input logic signed [COEF_W-1:0]    q1,
        input t_status                     flag
    );
        t_coefs                  r;
        t_sat                    s0, s1, s2, s3;
        logic signed [ACC_W-1:0] dpp, qs;
        dpp = ACC_W'(p1) - ACC_W'(p0);
        qs  = ACC_W'(q0) + ACC_W'(q1);
        s0  = sat_coef(ACC_W'(p0));
        s1  = sat_coef(ACC_W'(q0));
        s2  = sat_coef((dpp <<< 1) + dpp - (qs <<< 1));
        s3  = sat_coef(qs - (dpp <<< 1));
        r.a0 = s0.val;
        r.a1 = s1.val;
        r.a2 = s2.val;
        r.a3 = s3.val;
        r.status = (s0.ovf | s1.ovf | s2.ovf | s3.ovf) ? max_status(flag, ST_SAT) : flag;
        return r;
    endfunction

endpackage

@@ hw/rtl/hsc_if.sv @@
// ---------------------------------------------------------------------------
// hsc_if : stream interfaces for knots in and segments out
// Valid/ready channels; a transaction moves when both are high.
// ---------------------------------------------------------------------------
interface hsc_knot_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] knot_time;
    logic signed [31:0] knot_value;
    logic               final_knot;

    modport source (output valid, knot_time, knot_value, final_knot, input ready);
    modport sink   (input valid, knot_time, knot_value, final_knot, output ready);
endinterface

interface hsc_seg_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] segment_start;
    logic signed [47:0] coef_zero;
    logic signed [47:0] coef_one;
    logic signed [47:0] coef_two;
    logic signed [47:0] coef_three;
    logic               last_segment;
    logic [1:0]         status;

    modport source (output valid, segment_start, coef_zero, coef_one, coef_two,
                    coef_three, last_segment, status, input ready);
    modport sink   (input valid, segment_start, coef_zero, coef_one, coef_two,
                    coef_three, last_segment, status, output ready);
endinterface

@@ hw/rtl/hsc_queue.sv @@
// ---------------------------------------------------------------------------
// hsc_queue : short job queue between front and back
// Register-based FIFO, first-word read, push and pop in the same cycle.
// ---------------------------------------------------------------------------
module hsc_queue #(
    parameter int DEPTH = hsc_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hsc_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output hsc_pkg::t_job o_job
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hsc_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

@@ hw/rtl/hsc_front.sv @@
// ---------------------------------------------------------------------------
// hsc_front : knot intake and classification
// Keeps the last two knots, counts knots and queues one job per knot that
// produces segments.
// ---------------------------------------------------------------------------
module hsc_front #(
    parameter int VALUE_WIDTH = hsc_pkg::VALUE_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hsc_knot_if.sink      i_knot,
    input  logic          i_full,
    output logic          o_push,
    output hsc_pkg::t_job o_job
);
    localparam int VW = VALUE_WIDTH;
    localparam int MW = hsc_pkg::VAL_MAX_W;

    logic signed [VW-1:0] r_ot, r_nt, r_ov, r_nv;
    logic [1:0]           r_cnt;
    logic signed [VW-1:0] w_t, w_v;
    logic                 w_acc;

    assign w_t          = VW'(i_knot.knot_time);
    assign w_v          = VW'(i_knot.knot_value);
    assign i_knot.ready = !i_full;
    assign w_acc        = i_knot.valid && !i_full;

    // job build
    always_comb begin
        o_job.err         = (r_cnt < 2'd2);
        o_job.first       = (r_cnt == 2'd2);
        o_job.fin         = i_knot.final_knot;
        o_job.dp          = (MW + 1)'(w_v) - (MW + 1)'(r_ov);
        o_job.dt          = (MW + 1)'(w_t) - (MW + 1)'(r_ot);
        o_job.older_time  = MW'(r_ot);
        o_job.older_value = MW'(r_ov);
        o_job.newer_time  = MW'(r_nt);
        o_job.newer_value = MW'(r_nv);
        o_job.cur_value   = MW'(w_v);
        // early knots produce nothing unless they close the curve
        o_push = w_acc && ((r_cnt >= 2'd2) || i_knot.final_knot);
    end

    // knot history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ot  <= '0;
            r_nt  <= '0;
            r_ov  <= '0;
            r_nv  <= '0;
            r_cnt <= '0;
        end else if (w_acc) begin
            r_ot <= r_nt;
            r_ov <= r_nv;
            r_nt <= w_t;
            r_nv <= w_v;
            if (i_knot.final_knot) begin
                r_cnt <= '0;
            end else if (r_cnt != 2'd3) begin
                r_cnt <= r_cnt + 2'd1;
            end
        end
    end
endmodule

@@ hw/rtl/hsc_back.sv @@
// ---------------------------------------------------------------------------
// hsc_back : tangent divider and coefficient engine
// Restoring divider, one quotient bit per cycle, then tangents and up to
// two segments into a registered output stage.
// ---------------------------------------------------------------------------
module hsc_back #(
    parameter int VALUE_WIDTH = hsc_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = hsc_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  hsc_pkg::t_job i_job,
    output logic          o_pop,
    hsc_seg_if.source     o_seg
);
    localparam int MW    = hsc_pkg::VAL_MAX_W;
    localparam int CW    = hsc_pkg::COEF_W;
    localparam int AW    = hsc_pkg::ACC_W;
    localparam int DEN_W = VALUE_WIDTH + 1;
    localparam int NUM_W = DEN_W + FRAC_BITS;
    localparam int KW    = $clog2(NUM_W + 1);
    localparam int XW    = NUM_W + CW;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_TAN  = 6'b000100,
        S_ENDT = 6'b001000,
        S_SEG1 = 6'b010000,
        S_SEG2 = 6'b100000
    } t_state;

    t_state                r_state;
    hsc_pkg::t_job         r_job;
    logic [NUM_W-1:0]      r_quo;
    logic [DEN_W-1:0]      r_rem, r_den;
    logic [KW-1:0]         r_cnt;
    logic signed [CW-1:0]  r_qmid, r_qprev, r_qend, r_pend_q;
    hsc_pkg::t_status      r_fmid, r_fprev, r_fend, r_pend_f;

    logic                  r_valid;
    logic signed [31:0]    r_start;
    hsc_pkg::t_coefs       r_out;
    logic                  r_last;

    logic [MW:0]           w_nm, w_dm;
    logic [DEN_W:0]        w_trial;
    logic                  w_ge, w_slot, w_load, w_neg, w_ovf;
    logic [CW-1:0]         w_qmag;
    logic signed [CW-1:0]  w_qmid;
    hsc_pkg::t_status      w_fmid;
    hsc_pkg::t_sat         w_sprev, w_send;
    hsc_pkg::t_coefs       w_seg;

    // magnitudes of the incoming job
    assign w_nm = i_job.dp[MW] ? (MW + 1)'(-i_job.dp) : (MW + 1)'(i_job.dp);
    assign w_dm = i_job.dt[MW] ? (MW + 1)'(-i_job.dt) : (MW + 1)'(i_job.dt);

    // divider step
    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // tangent from quotient
    always_comb begin
        w_neg  = r_job.dp[MW] ^ r_job.dt[MW];
        w_ovf  = (XW'(r_quo) > XW'(hsc_pkg::CMAX));
        w_qmag = CW'(r_quo);
        w_fmid = hsc_pkg::ST_OK;
        w_qmid = w_neg ? -w_qmag : w_qmag;
        if (r_den == '0) begin
            w_fmid = hsc_pkg::ST_ZERO_GAP;
            if (r_job.dp == '0) begin
                w_qmid = '0;
            end else begin
                w_qmid = r_job.dp[MW] ? hsc_pkg::CMIN : hsc_pkg::CMAX;
            end
        end else if (w_ovf) begin
            w_fmid = hsc_pkg::ST_SAT;
            w_qmid = w_neg ? hsc_pkg::CMIN : hsc_pkg::CMAX;
        end
    end

    // end tangents: 2*(end difference) - neighbour
    assign w_sprev = hsc_pkg::sat_coef(((AW'(r_job.newer_value) - AW'(r_job.older_value)) <<< 1)
                                       - AW'(r_qmid));
    assign w_send  = hsc_pkg::sat_coef(((AW'(r_job.cur_value) - AW'(r_job.newer_value)) <<< 1)
                                       - AW'(r_qmid));

    // one coefficient unit, operands chosen by segment
    always_comb begin
        if (r_state == S_SEG2) begin
            w_seg = hsc_pkg::make_seg(r_job.newer_value, r_job.cur_value, r_qmid, r_qend,
                                      r_fend);
        end else begin
            w_seg = hsc_pkg::make_seg(r_job.older_value, r_job.newer_value, r_qprev, r_qmid,
                                      hsc_pkg::max_status(r_fprev, r_fmid));
        end
    end

    assign w_slot = !r_valid || o_seg.ready;
    assign w_load = w_slot && ((r_state == S_SEG1) || (r_state == S_SEG2));
    assign o_pop  = (r_state == S_IDLE) && !i_empty;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend_q <= '0;
            r_pend_f <= hsc_pkg::ST_OK;
            r_cnt    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cnt   <= KW'(NUM_W);
                        r_state <= i_job.err ? S_SEG1 : S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == KW'(1)) begin
                        r_state <= S_TAN;
                    end
                end
                S_TAN: r_state <= S_ENDT;
                S_ENDT: r_state <= S_SEG1;
                S_SEG1: begin
                    if (w_slot) begin
                        if (!r_job.err) begin
                            r_pend_q <= r_qmid;
                            r_pend_f <= r_fmid;
                        end
                        r_state <= (r_job.fin && !r_job.err) ? S_SEG2 : S_IDLE;
                    end
                end
                S_SEG2: begin
                    if (w_slot) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_den <= DEN_W'(w_dm);
            r_quo <= {w_nm[DEN_W-1:0], {FRAC_BITS{1'b0}}};
            r_rem <= '0;
        end
        if (r_state == S_DIV) begin
            r_rem <= w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : DEN_W'(w_trial);
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
        if (r_state == S_TAN) begin
            r_qmid <= w_qmid;
            r_fmid <= w_fmid;
        end
        if (r_state == S_ENDT) begin
            if (r_job.first) begin
                r_qprev <= w_sprev.val;
                r_fprev <= w_sprev.ovf ? hsc_pkg::max_status(r_fmid, hsc_pkg::ST_SAT) : r_fmid;
            end else begin
                r_qprev <= r_pend_q;
                r_fprev <= r_pend_f;
            end
            r_qend <= w_send.val;
            r_fend <= w_send.ovf ? hsc_pkg::max_status(r_fmid, hsc_pkg::ST_SAT) : r_fmid;
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (o_seg.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_state == S_SEG2) begin
                r_start <= 32'(r_job.newer_time);
                r_out   <= w_seg;
                r_last  <= 1'b1;
            end else if (r_job.err) begin
                r_start <= '0;
                r_out   <= '{a0: '0, a1: '0, a2: '0, a3: '0,
                             status: hsc_pkg::ST_FEW_KNOTS};
                r_last  <= 1'b1;
            end else begin
                r_start <= 32'(r_job.older_time);
                r_out   <= w_seg;
                r_last  <= 1'b0;
            end
        end
    end

    assign o_seg.valid         = r_valid;
    assign o_seg.segment_start = r_start;
    assign o_seg.coef_zero     = r_out.a0;
    assign o_seg.coef_one      = r_out.a1;
    assign o_seg.coef_two      = r_out.a2;
    assign o_seg.coef_three    = r_out.a3;
    assign o_seg.last_segment  = r_last;
    assign o_seg.status        = r_out.status;

    // checks
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == KW'(1)) |=> (r_state == S_TAN))
        else $error("divider did not hand over to tangent stage");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAN && r_den != '0) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_seg2_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEG2) |-> (r_job.fin && !r_job.err))
        else $error("closing segment without final knot");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_seg.ready) |-> !w_load)
        else $error("output register overwritten while stalled");
endmodule

@@ hw/rtl/hermite_spline_coefficient_builder_core.sv @@
// ---------------------------------------------------------------------------
// hermite_spline_coefficient_builder_core : cubic Hermite segment builder
// Knot stream in, per-segment start time and cubic coefficients out.
// ---------------------------------------------------------------------------
// Channels: i_knot takes one knot (time, value, final flag) per transaction;
// o_seg gives one segment per transaction (start time, a0..a3, last flag,
// status). Both are valid/ready.
// The first two knots of a curve give nothing unless one closes the curve, in
// which case a single flagged segment comes out. Every later knot gives one
// segment, a final knot two.
// Flow: each producing knot passes a restoring divider that yields
// VALUE_WIDTH+1+FRAC_BITS quotient bits (49 by default), then the tangent
// states S_TAN and S_ENDT and a segment state per segment (S_SEG1, S_SEG2)
// into the output register. A curve closed with too few knots skips the
// divider and goes straight to S_SEG1.
// A two-entry job queue lets knots be taken while the divider is busy; the
// output register lets work continue while a segment waits.
// When the receiver stalls, the segment holds, the back end waits, and once
// the queue fills the input ready drops.
// Reset clears knot history, pending tangent, queue and output valid.
// ---------------------------------------------------------------------------
module hermite_spline_coefficient_builder_core #(
    parameter int FRAC_BITS   = hsc_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = hsc_pkg::VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hsc_knot_if.sink  i_knot,
    hsc_seg_if.source o_seg
);
    logic          w_push, w_full, w_pop, w_empty;
    hsc_pkg::t_job w_job_in, w_job_out;

    hsc_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_knot (i_knot),
        .i_full (w_full),
        .o_push (w_push),
        .o_job  (w_job_in)
    );

    hsc_queue #(
        .DEPTH(hsc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_job_in),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_empty(w_empty),
        .o_job  (w_job_out)
    );

    hsc_back #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(w_empty),
        .i_job  (w_job_out),
        .o_pop  (w_pop),
        .o_seg  (o_seg)
    );
endmodule

@@ tb/hermite_spline_coefficient_builder_core_tb.sv @@
// ---------------------------------------------------------------------------
// hermite_spline_coefficient_builder_core_tb : self-checking bench
// Streams knot curves through the block and predicts every segment's start
// time, coefficients, last flag and status from a behavioural copy of the
// tangent and coefficient maths. Both channels stall at random.
// ---------------------------------------------------------------------------
module hermite_spline_coefficient_builder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT = 2000000;
    localparam longint      C48_MAX     = (longint'(1) <<< 47) - 1;
    localparam longint      C48_MIN     = -(longint'(1) <<< 47);

    typedef struct {
        logic [31:0]      start;
        logic [47:0]      c0, c1, c2, c3;
        logic             last;
        hsc_pkg::t_status st;
    } t_seg;

    logic clk;
    logic i_rst_n;
    hsc_knot_if knot_bus ();
    hsc_seg_if  seg_bus ();

    hermite_spline_coefficient_builder_core dut (
        .i_clk   (clk),
        .i_rst_n (i_rst_n),
        .i_knot  (knot_bus.sink),
        .o_seg   (seg_bus.source)
    );

    // knot history and pending tangent of the predictor
    longint           hist_old_t, hist_new_t, hist_old_v, hist_new_v;
    longint           held_slope;
    hsc_pkg::t_status held_flag;
    int               hist_count;

    t_seg    segs_due[$];
    int      n_errors = 0;
    int      cycles = 0;
    bit      calm;

    // clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic hsc_pkg::t_status worst(hsc_pkg::t_status a, hsc_pkg::t_status b);
        return (a > b) ? a : b;
    endfunction

    function automatic longint clamp48(longint v, inout bit ovf);
        if (v > C48_MAX) begin
            ovf = 1'b1;
            return C48_MAX;
        end
        if (v < C48_MIN) begin
            ovf = 1'b1;
            return C48_MIN;
        end
        return v;
    endfunction

    // (dp << 16) / dt toward zero, bit-serial on magnitudes
    function automatic longint gap_slope(longint dp, longint dt,
                                         inout hsc_pkg::t_status fl);
        bit     neg;
        longint nm, dm, ip, rem, q;
        neg = (dp < 0) != (dt < 0);
        nm  = (dp < 0) ? -dp : dp;
        dm  = (dt < 0) ? -dt : dt;
        if (dm == 0) begin
            fl = hsc_pkg::ST_ZERO_GAP;
            return (dp > 0) ? C48_MAX : (dp < 0) ? C48_MIN : 0;
        end
        ip  = nm / dm;
        rem = nm % dm;
        if (ip >= (longint'(1) <<< 31)) begin
            if (fl < hsc_pkg::ST_SAT) fl = hsc_pkg::ST_SAT;
            return neg ? C48_MIN : C48_MAX;
        end
        q = ip;
        for (int k = 0; k < 16; k++) begin
            rem = rem <<< 1;
            q   = q <<< 1;
            if (rem >= dm) begin
                rem = rem - dm;
                q   = q | 1;
            end
        end
        return neg ? -q : q;
    endfunction

    function automatic longint end_slope(longint pa, longint pb, longint qn,
                                         inout hsc_pkg::t_status fl);
        bit     ovf;
        longint r;
        ovf = 1'b0;
        r   = clamp48(2 * (pb - pa) - qn, ovf);
        if (ovf) fl = worst(fl, hsc_pkg::ST_SAT);
        return r;
    endfunction

    function automatic t_seg build_seg(longint ts, longint p0, longint p1, longint q0,
                                       longint q1, hsc_pkg::t_status fl, bit last);
        t_seg s;
        bit   ovf;
        ovf     = 1'b0;
        s.start = ts[31:0];
        s.c0    = 48'(clamp48(p0, ovf));
        s.c1    = 48'(clamp48(q0, ovf));
        s.c2    = 48'(clamp48(-3 * p0 + 3 * p1 - 2 * q0 - 2 * q1, ovf));
        s.c3    = 48'(clamp48(2 * p0 - 2 * p1 + q0 + q1, ovf));
        s.last  = last;
        s.st    = ovf ? worst(fl, hsc_pkg::ST_SAT) : fl;
        return s;
    endfunction

    // append one predicted segment to the expected list
    function automatic void expect_seg(t_seg s);
        segs_due.insert(segs_due.size(), s);
    endfunction

    // predicted segments for one accepted knot
    task automatic predict_knot(logic [31:0] kt, logic [31:0] kv, bit fin);
        longint           t, v, qmid, qprev, qend;
        hsc_pkg::t_status fmid, fprev, fend;
        t_seg             s;
        t = longint'(signed'(kt));
        v = longint'(signed'(kv));
        if (hist_count < 2) begin
            hist_old_t = hist_new_t;
            hist_old_v = hist_new_v;
            hist_new_t = t;
            hist_new_v = v;
            hist_count++;
            if (fin) begin
                s = '{start: '0, c0: '0, c1: '0, c2: '0, c3: '0, last: 1'b1,
                      st: hsc_pkg::ST_FEW_KNOTS};
                expect_seg(s);
                hist_count = 0;
            end
            return;
        end
        fmid = hsc_pkg::ST_OK;
        qmid = gap_slope(v - hist_old_v, t - hist_old_t, fmid);
        if (hist_count == 2) begin
            fprev = fmid;
            qprev = end_slope(hist_old_v, hist_new_v, qmid, fprev);
        end else begin
            fprev = held_flag;
            qprev = held_slope;
        end
        expect_seg(build_seg(hist_old_t, hist_old_v, hist_new_v, qprev, qmid,
                             worst(fprev, fmid), 1'b0));
        if (fin) begin
            fend = fmid;
            qend = end_slope(hist_new_v, v, qmid, fend);
            expect_seg(build_seg(hist_new_t, hist_new_v, v, qmid, qend, fend, 1'b1));
            hist_count = 0;
        end else begin
            hist_count = 3;
        end
        held_slope = qmid;
        held_flag  = fmid;
        hist_old_t = hist_new_t;
        hist_old_v = hist_new_v;
        hist_new_t = t;
        hist_new_v = v;
    endtask

    task automatic report_mismatch(string field, longint got, longint want);
        $display("[%0t] segment %s: got %0h, expected %0h", $realtime, field, got, want);
        n_errors++;
    endtask

    // send one knot; waits for its transaction, then may idle
    task automatic send_knot(logic [31:0] kt, logic [31:0] kv, bit fin);
        knot_bus.valid      <= 1'b1;
        knot_bus.knot_time  <= kt;
        knot_bus.knot_value <= kv;
        knot_bus.final_knot <= fin;
        do @(posedge clk); while (!knot_bus.ready);
        predict_knot(kt, kv, fin);
        if (!calm && $urandom_range(99) < 38) begin
            knot_bus.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    // segment receiver: check each transaction, stall at random
    always @(posedge clk) begin
        t_seg w;
        if (i_rst_n && seg_bus.valid && seg_bus.ready) begin
            if (segs_due.size() == 0) begin
                report_mismatch("unexpected", 1, 0);
            end else begin
                w = segs_due.pop_front();
                if (seg_bus.segment_start !== w.start)
                    report_mismatch("start", seg_bus.segment_start, w.start);
                if (seg_bus.coef_zero !== w.c0) report_mismatch("a0", seg_bus.coef_zero, w.c0);
                if (seg_bus.coef_one !== w.c1) report_mismatch("a1", seg_bus.coef_one, w.c1);
                if (seg_bus.coef_two !== w.c2) report_mismatch("a2", seg_bus.coef_two, w.c2);
                if (seg_bus.coef_three !== w.c3)
                    report_mismatch("a3", seg_bus.coef_three, w.c3);
                if (seg_bus.last_segment !== w.last)
                    report_mismatch("last", seg_bus.last_segment, w.last);
                if (seg_bus.status !== w.st) report_mismatch("status", seg_bus.status, w.st);
            end
        end
        seg_bus.ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
    end

    // curves of one and two knots, closed early, and a three-knot curve
    task automatic test_short_curves();
        send_knot(32'h0001_0000, 32'h0005_0000, 1'b1);
        send_knot(32'h0001_0000, 32'h0005_0000, 1'b0);
        send_knot(32'h0002_0000, 32'hFFFB_0000, 1'b1);
        send_knot(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_knot(32'h0001_0000, 32'h0001_0000, 1'b0);
        send_knot(32'h0002_0000, 32'h0004_0000, 1'b1);
    endtask

    // field extremes, including full-range time jumps
    task automatic test_extremes();
        send_knot(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_knot(32'h8000_0001, 32'h7FFF_FFFF, 1'b0);
        send_knot(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_knot(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_knot(32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
    endtask

    // zero time gaps with rising, falling and flat values
    task automatic test_zero_gap();
        send_knot(32'h0001_0000, 32'h0000_1000, 1'b0);
        send_knot(32'h0002_0000, 32'h0000_2000, 1'b0);
        send_knot(32'h0001_0000, 32'h0000_3000, 1'b0);
        send_knot(32'h0002_0000, 32'h0000_0000, 1'b0);
        send_knot(32'h0003_0000, 32'h0000_0000, 1'b0);
        send_knot(32'h0002_0000, 32'h0000_0000, 1'b1);
    endtask

    // steep slopes and a backward time step
    task automatic test_saturation();
        send_knot(32'h0000_0000, 32'h8000_0000, 1'b0);
        send_knot(32'h0000_0001, 32'h0000_0000, 1'b0);
        send_knot(32'h0000_0002, 32'h7FFF_FFFF, 1'b0);
        send_knot(32'h0000_0001, 32'h0010_0000, 1'b1);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0, 1:    return $urandom();
            2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(32'h0040_0000) - 32'h0020_0000;
        endcase
    endfunction

    // random well-formed curves, with some broken gaps
    task automatic test_random_curves(int n_knots);
        logic [31:0] t;
        int          len, sent;
        sent = 0;
        while (sent < n_knots) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(12, 3);
            t   = $urandom();
            for (int k = 0; k < len; k++) begin
                calm = (sent >= 400 && sent < 600);
                case ($urandom_range(19))
                    0:       t = t;
                    1:       t = t - $urandom_range(32'h0003_0000);
                    2, 3:    t = t + $urandom();
                    default: t = t + $urandom_range(32'h0004_0000, 1);
                endcase
                send_knot(t, pick_value(), k == len - 1);
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n             = 1'b0;
        knot_bus.valid      = 1'b0;
        knot_bus.knot_time  = '0;
        knot_bus.knot_value = '0;
        knot_bus.final_knot = 1'b0;
        calm                = 1'b0;
        hist_old_t = 0; hist_new_t = 0; hist_old_v = 0; hist_new_v = 0;
        held_slope = 0; held_flag = hsc_pkg::ST_OK; hist_count = 0;
        repeat (9) @(posedge clk);
        i_rst_n <= 1'b1;
        @(posedge clk);

        test_short_curves();
        test_extremes();
        test_zero_gap();
        test_saturation();
        test_random_curves(1480);

        knot_bus.valid <= 1'b0;
        while (segs_due.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
